FILE: rtl/ncc_pkg.sv
// Package for the nearest-centroid classifier: request and result types,
// centroid row type, pipeline tag and fixed widths. No dependencies.
package ncc_pkg;

	// Fixed field and datapath widths
	localparam int LANES     = 8;
	localparam int VAL_W     = 24;
	localparam int DIFF_W    = VAL_W + 1;
	localparam int SQ_W      = 2 * VAL_W;
	localparam int PAIR_W    = SQ_W + 1;
	localparam int SUM_W     = SQ_W + 3;
	localparam int ACC_W     = 62;
	localparam int CFG_W     = 62;
	localparam int CFG_IDX_W = 2;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARK_THRESHOLD = 2'd2;

	// Register reset values
	localparam logic [3:0]       CLUSTER_COUNT_RST  = 4'd8;
	localparam logic [5:0]       GROUP_COUNT_RST    = 6'd32;
	localparam logic [CFG_W-1:0] MARK_THRESHOLD_RST = 62'd490000000000;

	// Request operation codes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef val_t [LANES-1:0] row_t;

	typedef struct packed {
		logic       operation;
		logic [2:0] cluster;
		logic [4:0] group;
		val_t       value_0;
		val_t       value_1;
		val_t       value_2;
		val_t       value_3;
		val_t       value_4;
		val_t       value_5;
		val_t       value_6;
		val_t       value_7;
	} sample_t;

	typedef struct packed {
		logic [2:0]       nearest_cluster;
		logic [ACC_W-1:0] squared_distance;
		logic             within_threshold;
	} result_t;

	// Travels with each centroid pass through the pipeline
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} tag_t;

endpackage

FILE: rtl/ncc_store.sv
// Centroid memory: one row of eight components per (cluster, group).
// Uses ncc_pkg for the row type. One write port, one registered read port.
module ncc_store
	import ncc_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  row_t          wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output row_t          rd_data_s1
);

	row_t mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/ncc_lane.sv
// One lane: difference of a sample component and a centroid component,
// then its square. Uses ncc_pkg for widths.
module ncc_lane
	import ncc_pkg::*;
(
	input  logic            clk,
	input  val_t            sample_val,
	input  val_t            centroid_val,
	output logic [SQ_W-1:0] sq_s3
);

	logic signed [DIFF_W-1:0]   diff_s2;
	logic signed [2*DIFF_W-1:0] prod;

	// Stage 2: signed difference
	always_ff @(posedge clk) begin
		diff_s2 <= DIFF_W'(sample_val) - DIFF_W'(centroid_val);
	end

	// Stage 3: square; |diff| < 2^24 so the low bits hold it exactly
	assign prod = diff_s2 * diff_s2;

	always_ff @(posedge clk) begin
		sq_s3 <= prod[SQ_W-1:0];
	end

endmodule

FILE: rtl/ncc_merge.sv
// Merging stage: sums the eight lane squares in a two-stage adder tree.
// Uses ncc_pkg for widths and the pipeline tag.
module ncc_merge
	import ncc_pkg::*;
#(
	parameter int IDX_W = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tag_t                       tag_s1,
	input  logic [IDX_W-1:0]           idx_s1,
	input  logic [LANES-1:0][SQ_W-1:0] sq_s3,
	output tag_t                       tag_s5,
	output logic [IDX_W-1:0]           idx_s5,
	output logic [SUM_W-1:0]           sum_s5
);

	tag_t                         tag_s2, tag_s3, tag_s4;
	logic [IDX_W-1:0]             idx_s2, idx_s3, idx_s4;
	logic [LANES/2-1:0][PAIR_W-1:0] pair_s4;

	// Tag and cluster index follow the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		idx_s5 <= idx_s4;
	end

	// Stage 4: pairwise sums
	always_ff @(posedge clk) begin
		for (int p = 0; p < LANES/2; p++) begin
			pair_s4[p] <= PAIR_W'(sq_s3[2*p]) + PAIR_W'(sq_s3[2*p+1]);
		end
	end

	// Stage 5: remaining two levels
	always_ff @(posedge clk) begin
		sum_s5 <= (SUM_W'(pair_s4[0]) + SUM_W'(pair_s4[1]))
			+ (SUM_W'(pair_s4[2]) + SUM_W'(pair_s4[3]));
	end

endmodule

FILE: rtl/ncc_accum.sv
// Per-cluster saturating distance accumulators and the running minimum.
// Uses ncc_pkg for widths and the pipeline tag.
module ncc_accum
	import ncc_pkg::*;
#(
	parameter int CLUSTERS = 8,
	parameter int IDX_W    = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  tag_t             tag_s5,
	input  logic [IDX_W-1:0] idx_s5,
	input  logic [SUM_W-1:0] sum_s5,
	output logic             fin_s7,
	output logic [ACC_W-1:0] best_dist_q,
	output logic [IDX_W-1:0] best_idx_q
);

	logic [ACC_W-1:0] acc_q [CLUSTERS];
	logic [ACC_W:0]   acc_sum;
	logic [ACC_W-1:0] acc_new;
	logic [ACC_W-1:0] new_s6;
	logic [IDX_W-1:0] idx_s6;
	tag_t             tag_s6;

	// Saturating add of this group's sum
	assign acc_sum = {1'b0, acc_q[idx_s5]} + (ACC_W+1)'(sum_s5);
	assign acc_new = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

	// Stage 6: accumulator update; group zero clears them all first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CLUSTERS; c++) begin
				acc_q[c] <= '0;
			end
			tag_s6 <= '0;
		end else begin
			if (clr) begin
				for (int c = 0; c < CLUSTERS; c++) begin
					acc_q[c] <= '0;
				end
			end else if (tag_s5.vld) begin
				acc_q[idx_s5] <= acc_new;
			end
			tag_s6 <= tag_s5;
		end
	end

	always_ff @(posedge clk) begin
		new_s6 <= acc_new;
		idx_s6 <= idx_s5;
	end

	// Stage 7: running minimum; clusters arrive in ascending order so a
	// strict compare keeps the lower index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s7 <= 1'b0;
		end else begin
			fin_s7 <= tag_s6.vld && tag_s6.last;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s6.vld && (tag_s6.first || (new_s6 < best_dist_q))) begin
			best_dist_q <= new_s6;
			best_idx_q  <= idx_s6;
		end
	end

endmodule

FILE: rtl/nearest_centroid_classifier.sv
// Nearest-centroid classifier. A load request is written as it is accepted
// and leaves the block idle. A sample group stalls requests until its pass
// over the N active clusters is done; the final group also shows its result.
// One centroid row is read and compared per cycle by eight lanes.
// Reset clears control, the accumulators and the registers to their reset
// values; the centroid memory holds garbage until loaded.
module nearest_centroid_classifier
	import ncc_pkg::*;
#(
	parameter int MAX_CLUSTERS = 8,
	parameter int MAX_GROUPS   = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  sample_t              sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int IDX_W = $clog2(MAX_CLUSTERS);
	localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);
	localparam int EW    = (CNT_W > 4) ? CNT_W : 4;
	localparam int GCW   = $clog2(MAX_GROUPS + 1);
	localparam int EGW   = (GCW > 6) ? GCW : 6;
	localparam int DEPTH = MAX_CLUSTERS * MAX_GROUPS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_REPORT
	} state_t;

	state_t           state_q;
	logic [3:0]       cluster_count_q;
	logic [5:0]       group_count_q;
	logic [CFG_W-1:0] mark_threshold_q;

	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] last_idx_q;
	logic [4:0]       grp_q;
	logic             final_q;
	row_t             vals_q;
	logic             out_vld_q;
	result_t          out_q;

	logic [EW-1:0]    cc_ext, eff_clusters;
	logic [EGW-1:0]   grp_ext, eff_groups;
	logic             accept, is_load, load_ok, sample_ok, sample_final;
	row_t             in_row;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic             rd_en;
	row_t             rd_data_s1;
	tag_t             tag_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [LANES-1:0][SQ_W-1:0] sq_s3;
	tag_t             tag_s5;
	logic [IDX_W-1:0] idx_s5;
	logic [SUM_W-1:0] sum_s5;
	logic             fin_s7;
	logic [ACC_W-1:0] best_dist_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             out_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q  <= CLUSTER_COUNT_RST;
			group_count_q    <= GROUP_COUNT_RST;
			mark_threshold_q <= MARK_THRESHOLD_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_CLUSTER_COUNT:  cluster_count_q  <= cfg_wdata[3:0];
				REG_GROUP_COUNT:    group_count_q    <= cfg_wdata[5:0];
				REG_MARK_THRESHOLD: mark_threshold_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Effective counts, clamped to 1..max
	assign cc_ext       = EW'(cluster_count_q);
	assign eff_clusters = (cc_ext == '0) ? EW'(1) :
		((cc_ext > EW'(MAX_CLUSTERS)) ? EW'(MAX_CLUSTERS) : cc_ext);
	assign eff_groups   = (group_count_q == '0) ? EGW'(1) :
		((EGW'(group_count_q) > EGW'(MAX_GROUPS)) ? EGW'(MAX_GROUPS)
			: EGW'(group_count_q));

	// Request decode
	assign accept       = sample_valid && !sample_stall;
	assign is_load      = (sample.operation == OP_LOAD);
	assign grp_ext      = EGW'(sample.group);
	assign load_ok      = (EW'(sample.cluster) < EW'(MAX_CLUSTERS))
		&& (grp_ext < EGW'(MAX_GROUPS));
	assign sample_ok    = (sample.operation == OP_SAMPLE) && (grp_ext < eff_groups);
	assign sample_final = (grp_ext == (eff_groups - EGW'(1)));
	assign in_row       = {sample.value_7, sample.value_6, sample.value_5, sample.value_4,
		sample.value_3, sample.value_2, sample.value_1, sample.value_0};

	assign sample_stall = (state_q != ST_IDLE);

	// Memory addressing: row = cluster * MAX_GROUPS + group
	assign wr_addr = AW'(AW'(sample.cluster) * AW'(MAX_GROUPS) + AW'(sample.group));
	assign rd_addr = AW'(AW'(cnt_q) * AW'(MAX_GROUPS) + AW'(grp_q));
	assign rd_en   = (state_q == ST_ISSUE);

	assign out_free = !out_vld_q || !result_stall;

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// filled from the report state, emptied when the result is taken
			if (state_q == ST_REPORT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && sample_ok) begin
						cnt_q   <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (cnt_q == last_idx_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (fin_s7) begin
						state_q <= final_q ? ST_REPORT : ST_IDLE;
					end
				end
				ST_REPORT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request payload held for the whole pass
	always_ff @(posedge clk) begin
		if (accept && sample_ok) begin
			grp_q      <= sample.group;
			final_q    <= sample_final;
			vals_q     <= in_row;
			last_idx_q <= IDX_W'(eff_clusters - EW'(1));
		end
		if (state_q == ST_REPORT && out_free) begin
			out_q.nearest_cluster  <= 3'(best_idx_q);
			out_q.squared_distance <= best_dist_q;
			out_q.within_threshold <= (best_dist_q < mark_threshold_q);
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

	// Stage 1 tag beside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld   <= rd_en;
			tag_s1.first <= (cnt_q == '0);
			tag_s1.last  <= (cnt_q == last_idx_q);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
	end

	ncc_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk        (clk),
		.wr_en      (accept && is_load && load_ok),
		.wr_addr    (wr_addr),
		.wr_data    (in_row),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data_s1 (rd_data_s1)
	);

	// Eight lanes side by side, one component each
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		ncc_lane u_lane (
			.clk          (clk),
			.sample_val   (vals_q[l]),
			.centroid_val (rd_data_s1[l]),
			.sq_s3        (sq_s3[l])
		);
	end

	ncc_merge #(
		.IDX_W (IDX_W)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_s1 (tag_s1),
		.idx_s1 (idx_s1),
		.sq_s3  (sq_s3),
		.tag_s5 (tag_s5),
		.idx_s5 (idx_s5),
		.sum_s5 (sum_s5)
	);

	ncc_accum #(
		.CLUSTERS (MAX_CLUSTERS),
		.IDX_W    (IDX_W)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.clr         (accept && sample_ok && (sample.group == '0)),
		.tag_s5      (tag_s5),
		.idx_s5      (idx_s5),
		.sum_s5      (sum_s5),
		.fin_s7      (fin_s7),
		.best_dist_q (best_dist_q),
		.best_idx_q  (best_idx_q)
	);

	// Issue counter stays within the active clusters
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (cnt_q <= last_idx_q))
		else $error("issue counter past last active cluster");

	// A fresh result only comes out of the report state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_REPORT))
		else $error("result raised outside report");

	// Pass completion only while draining
	a_fin_drain: assert property (@(posedge clk) disable iff (!arst_n)
		fin_s7 |-> (state_q == ST_DRAIN))
		else $error("pass finished outside drain");

	// Winner is an active cluster
	a_best_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPORT) |-> (best_idx_q <= last_idx_q))
		else $error("nearest cluster beyond active count");

endmodule

FILE: tb/ncc_checker.sv
// Checker for the nearest-centroid classifier: watches the request, result and
// register ports, keeps its own centroid table and distance sums, and compares.
// Depends on ncc_pkg for the request and result types and register indexes.
module ncc_checker
	import ncc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	input  logic                 sample_stall,
	input  sample_t              sample,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  result_t              result,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output int                   fail_count,
	output int                   open_count,
	output int                   result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLUSTERS = 8;
	localparam int GROUPS   = 32;

	// Register copies
	logic [3:0]       cluster_reg;
	logic [5:0]       group_reg;
	logic [CFG_W-1:0] threshold_reg;

	// Centroid table and running distance sums
	val_t             centroid_mem [CLUSTERS][GROUPS][LANES];
	logic [ACC_W-1:0] dist_acc [CLUSTERS];

	// Results still owed by the block, oldest first
	result_t          owed_results [$];

	initial begin
		fail_count   = 0;
		open_count   = 0;
		result_count = 0;
	end

	function automatic int live_clusters();
		if (cluster_reg == 4'd0)
			return 1;
		if (cluster_reg > CLUSTERS)
			return CLUSTERS;
		return int'(cluster_reg);
	endfunction

	function automatic int vector_groups();
		if (group_reg == 6'd0)
			return 1;
		if (group_reg > GROUPS)
			return GROUPS;
		return int'(group_reg);
	endfunction

	// Apply one accepted request; queue the nearest-centroid result when a
	// vector completes
	task automatic absorb_request(input sample_t r);
		val_t        lane [LANES];
		int          nc;
		int          ng;
		int          best;
		longint      diff;
		logic [63:0] group_sum;
		logic [63:0] headroom;
		result_t     res;
		lane[0] = r.value_0;
		lane[1] = r.value_1;
		lane[2] = r.value_2;
		lane[3] = r.value_3;
		lane[4] = r.value_4;
		lane[5] = r.value_5;
		lane[6] = r.value_6;
		lane[7] = r.value_7;

		// cluster and group fields always fall inside the table here
		if (r.operation == OP_LOAD) begin
			for (int i = 0; i < LANES; i++)
				centroid_mem[r.cluster][r.group][i] = lane[i];
			return;
		end

		ng = vector_groups();
		if (int'(r.group) >= ng)
			return;
		nc = live_clusters();

		if (r.group == 5'd0) begin
			for (int c = 0; c < CLUSTERS; c++)
				dist_acc[c] = '0;
		end

		// add this group's squared differences, saturating
		for (int c = 0; c < nc; c++) begin
			group_sum = '0;
			for (int i = 0; i < LANES; i++) begin
				diff = longint'(lane[i]) - longint'(centroid_mem[c][r.group][i]);
				group_sum += 64'(diff * diff);
			end
			headroom = 64'(ACC_MAX) - 64'(dist_acc[c]);
			if (group_sum > headroom)
				dist_acc[c] = ACC_MAX;
			else
				dist_acc[c] = dist_acc[c] + group_sum[ACC_W-1:0];
		end

		if (int'(r.group) != ng - 1)
			return;

		// strict less-than keeps the lower index on a tie
		best = 0;
		for (int c = 1; c < nc; c++)
			if (dist_acc[c] < dist_acc[best])
				best = c;

		res.nearest_cluster  = best[2:0];
		res.squared_distance = dist_acc[best];
		res.within_threshold = (dist_acc[best] < threshold_reg);
		owed_results.push_back(res);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (owed_results.size() == 0) begin
			$error("result with none owed: nearest_cluster %0d squared_distance %0d",
				got.nearest_cluster, got.squared_distance);
			fail_count++;
			return;
		end
		want = owed_results.pop_front();
		result_count++;
		if (got.nearest_cluster !== want.nearest_cluster) begin
			$error("nearest_cluster: expected %0d, got %0d",
				want.nearest_cluster, got.nearest_cluster);
			fail_count++;
		end
		if (got.squared_distance !== want.squared_distance) begin
			$error("squared_distance: expected %0d, got %0d",
				want.squared_distance, got.squared_distance);
			fail_count++;
		end
		if (got.within_threshold !== want.within_threshold) begin
			$error("within_threshold: expected %0b, got %0b",
				want.within_threshold, got.within_threshold);
			fail_count++;
		end
	endtask

	// Monitor: everything is sampled at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_reg   = CLUSTER_COUNT_RST;
			group_reg     = GROUP_COUNT_RST;
			threshold_reg = MARK_THRESHOLD_RST;
			for (int c = 0; c < CLUSTERS; c++)
				dist_acc[c] = '0;
			owed_results.delete();
			open_count = 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_CLUSTER_COUNT:  cluster_reg   = cfg_wdata[3:0];
					REG_GROUP_COUNT:    group_reg     = cfg_wdata[5:0];
					REG_MARK_THRESHOLD: threshold_reg = cfg_wdata;
					default: ;
				endcase
			end
			// a result never comes from a request accepted on the same edge
			if (result_valid && !result_stall)
				check_result(result);
			if (sample_valid && !sample_stall)
				absorb_request(sample);
			open_count = owed_results.size();
		end
	end

endmodule

FILE: tb/tb.sv
// Top of the nearest-centroid classifier testbench: clock, reset, register
// writes, request stimulus and result back-pressure, watchdog and verdict.
// Depends on ncc_pkg, nearest_centroid_classifier and ncc_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ncc_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 32;
	localparam int ITEM_TARGET  = 1400;

	localparam logic signed [VAL_W-1:0] VAL_MAX    = 24'sh7FFFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN    = 24'sh800000;
	localparam logic [CFG_W-1:0]        THRESH_TOP = {CFG_W{1'b1}};

	logic                 clk;
	logic                 arst_n;
	logic                 sample_valid;
	logic                 sample_stall;
	sample_t              sample;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	int fail_count;
	int open_count;
	int result_count;

	// Stimulus bookkeeping
	bit                       calm;
	int                       stall_left;
	int                       idle_cycles;
	int                       item_count;
	int                       ignored_count;
	int                       vector_count;
	int                       live_clusters_now;
	int                       live_groups_now;
	logic signed [VAL_W-1:0]  lanes_buf [LANES];
	int                       loaded_rows [8][32][LANES];

	nearest_centroid_classifier DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	ncc_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.open_count   (open_count),
		.result_count (result_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one; none in calm stretches
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return VAL_MAX;
			1:       return VAL_MIN;
			2:       return $urandom_range(0, 1) ? 24'sd0 : -24'sd1;
			default: return VAL_W'($urandom());
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] clamp24(input longint x);
		if (x > 64'sd8388607)
			return VAL_MAX;
		if (x < -64'sd8388608)
			return VAL_MIN;
		return x[VAL_W-1:0];
	endfunction

	function automatic int squeeze(input int v, input int hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	// Result back-pressure
	initial begin
		result_stall = 1'b0;
		stall_left   = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_stall = 1'b1;
				stall_left--;
			end else begin
				result_stall = 1'b0;
				stall_left   = pick_gap();
			end
		end
	end

	// Watchdog on cycles where neither channel moves
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Send one request built from lanes_buf; returns once it is accepted
	task automatic send_group(input logic op, input int cl, input int grp);
		sample_t r;
		int      gap;
		r.operation = op;
		r.cluster   = cl[2:0];
		r.group     = grp[4:0];
		r.value_0   = lanes_buf[0];
		r.value_1   = lanes_buf[1];
		r.value_2   = lanes_buf[2];
		r.value_3   = lanes_buf[3];
		r.value_4   = lanes_buf[4];
		r.value_5   = lanes_buf[5];
		r.value_6   = lanes_buf[6];
		r.value_7   = lanes_buf[7];
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample       = r;
		sample_valid = 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		if (op == OP_LOAD) begin
			item_count++;
			for (int i = 0; i < LANES; i++)
				loaded_rows[cl][grp][i] = int'(lanes_buf[i]);
		end else if (grp < live_groups_now) begin
			item_count++;
		end else begin
			ignored_count++;
		end
	endtask

	task automatic fill_random();
		for (int i = 0; i < LANES; i++)
			lanes_buf[i] = pick_value();
	endtask

	// Components scattered around a loaded centroid row
	task automatic fill_near(input int cl, input int grp, input int spread);
		for (int i = 0; i < LANES; i++)
			lanes_buf[i] = clamp24(longint'(loaded_rows[cl][grp][i]) +
				longint'($urandom_range(0, 2 * spread)) - longint'(spread));
	endtask

	task automatic fill_const(input logic signed [VAL_W-1:0] v);
		for (int i = 0; i < LANES; i++)
			lanes_buf[i] = v;
	endtask

	// Wait until the block owes nothing and has finished any silent work
	task automatic settle();
		@(negedge clk);
		sample_valid = 1'b0;
		wait (open_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_wen   = 1'b0;
	endtask

	task automatic configure(input int cc, input int gc, input logic [CFG_W-1:0] th);
		settle();
		write_reg(REG_CLUSTER_COUNT, CFG_W'(cc));
		write_reg(REG_GROUP_COUNT, CFG_W'(gc));
		write_reg(REG_MARK_THRESHOLD, th);
		live_clusters_now = squeeze(cc, 8);
		live_groups_now   = squeeze(gc, 32);
	endtask

	// One random phase: new register values, then a run of vectors
	task automatic run_phase();
		int               cc;
		int               gc;
		int               n_vec;
		int               style;
		int               target;
		int               mode;
		int               spread;
		int               a;
		int               b;
		int               steps;
		logic [63:0]      wide;
		logic [CFG_W-1:0] th;
		case ($urandom_range(0, 9))
			0:       cc = 0;
			1:       cc = 1;
			2:       cc = 8;
			3:       cc = 15;
			default: cc = $urandom_range(0, 15);
		endcase
		case ($urandom_range(0, 19))
			0:          gc = 0;
			1:          gc = 32;
			2:          gc = 63;
			3, 4, 5, 6: gc = $urandom_range(5, 16);
			default:    gc = $urandom_range(1, 4);
		endcase
		wide = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0:       th = '0;
			1:       th = THRESH_TOP;
			2:       th = MARK_THRESHOLD_RST;
			3:       th = wide[CFG_W-1:0];
			default: th = CFG_W'(wide >> $urandom_range(8, 14));
		endcase
		calm = ($urandom_range(0, 3) == 0);
		configure(cc, gc, th);

		// sometimes duplicate one centroid into a higher slot to force ties
		if ($urandom_range(0, 9) < 3) begin
			a = $urandom_range(0, 6);
			b = $urandom_range(a + 1, 7);
			for (int g = 0; g < live_groups_now; g++) begin
				for (int i = 0; i < LANES; i++)
					lanes_buf[i] = VAL_W'(loaded_rows[a][g][i]);
				send_group(OP_LOAD, b, g);
			end
		end

		n_vec = (live_groups_now <= 4) ? $urandom_range(6, 20) : $urandom_range(1, 3);
		for (int v = 0; v < n_vec; v++) begin
			style = $urandom_range(0, 99);
			if (style < 75) begin
				// well-formed vector, groups in order
				vector_count++;
				target = $urandom_range(0, live_clusters_now - 1);
				mode   = $urandom_range(0, 3);
				spread = (mode == 2) ? 0 : (1 << $urandom_range(0, 20));
				for (int g = 0; g < live_groups_now; g++) begin
					if ($urandom_range(0, 9) == 0) begin
						fill_random();
						send_group(OP_LOAD, $urandom_range(0, 7), $urandom_range(0, 31));
					end
					case (mode)
						0: fill_random();
						3: begin
							for (int i = 0; i < LANES; i++)
								lanes_buf[i] = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
						end
						default: fill_near(target, g, spread);
					endcase
					send_group(OP_SAMPLE, $urandom_range(0, 7), g);
				end
			end else if (style < 90) begin
				// broken vector: groups shuffled, missing or out of range
				steps = $urandom_range(1, live_groups_now + 2);
				for (int s = 0; s < steps; s++) begin
					fill_random();
					send_group(OP_SAMPLE, $urandom_range(0, 7), $urandom_range(0, 1) ?
						$urandom_range(0, live_groups_now - 1) : $urandom_range(0, 31));
				end
			end else begin
				// burst of centroid rewrites
				steps = $urandom_range(1, 6);
				for (int s = 0; s < steps; s++) begin
					fill_random();
					send_group(OP_LOAD, $urandom_range(0, 7), $urandom_range(0, 31));
				end
			end
		end
	endtask

	// Main sequence
	initial begin
		arst_n            = 1'b0;
		sample_valid      = 1'b0;
		sample            = '0;
		cfg_wen           = 1'b0;
		cfg_index         = REG_CLUSTER_COUNT;
		cfg_wdata         = '0;
		calm              = 1'b0;
		item_count        = 0;
		ignored_count     = 0;
		vector_count      = 0;
		live_clusters_now = 8;
		live_groups_now   = 32;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// write every centroid row so no sample reads an empty entry
		for (int c = 0; c < 8; c++)
			for (int g = 0; g < 32; g++) begin
				fill_random();
				send_group(OP_LOAD, c, g);
			end

		// clusters 0 and 1 identical, cluster 2 at the other extreme;
		// zero distance against a zero threshold, ties, ignored groups
		configure(15, 0, '0);
		fill_const(VAL_MAX);
		send_group(OP_LOAD, 0, 0);
		send_group(OP_LOAD, 1, 0);
		fill_const(VAL_MIN);
		send_group(OP_LOAD, 2, 0);
		fill_const(VAL_MAX);
		send_group(OP_SAMPLE, 7, 0);
		fill_const(VAL_MIN);
		send_group(OP_SAMPLE, 0, 0);
		for (int i = 0; i < LANES; i++)
			lanes_buf[i] = i[0] ? VAL_MIN : VAL_MAX;
		send_group(OP_SAMPLE, 5, 0);
		send_group(OP_SAMPLE, 2, 1);
		send_group(OP_SAMPLE, 2, 31);

		// single cluster, two groups, top threshold; load inside a vector,
		// a last group without its first, then a restart
		configure(0, 2, THRESH_TOP);
		fill_random();
		send_group(OP_SAMPLE, 0, 0);
		fill_random();
		send_group(OP_LOAD, 0, 1);
		fill_random();
		send_group(OP_SAMPLE, 0, 1);
		fill_random();
		send_group(OP_SAMPLE, 0, 1);
		fill_random();
		send_group(OP_SAMPLE, 0, 0);
		fill_random();
		send_group(OP_SAMPLE, 0, 1);

		// oversized group count clamps to the full vector
		configure(1, 63, MARK_THRESHOLD_RST);
		fill_near(0, 31, 0);
		send_group(OP_SAMPLE, 3, 31);

		// exact match on a middle cluster
		configure(8, 1, MARK_THRESHOLD_RST);
		fill_near(5, 0, 0);
		send_group(OP_SAMPLE, 6, 0);

		while (item_count < ITEM_TARGET)
			run_phase();

		settle();
		$display("Accepted %0d requests (%0d more outside the vector), %0d full vectors",
			item_count, ignored_count, vector_count);
		$display("Checked %0d nearest-centroid results with %0d mismatches",
			result_count, fail_count);
		if (fail_count == 0 && open_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/ncc_pkg.sv
rtl/ncc_store.sv
rtl/ncc_lane.sv
rtl/ncc_merge.sv
rtl/ncc_accum.sv
rtl/nearest_centroid_classifier.sv
tb/ncc_checker.sv
tb/tb.sv
